@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the list engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cal_pkg.sv @@
// ----------------------------------------------------------------------------
// cal_pkg
// Field types, operation and status codes, and controller/datapath bundles
// for the compacting array list.
// ----------------------------------------------------------------------------
package cal_pkg;

  // Port field widths
  localparam int KIND_W = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Operation codes
  localparam kind_t OP_APPEND = 3'd0;
  localparam kind_t OP_GET    = 3'd1;
  localparam kind_t OP_SET    = 3'd2;
  localparam kind_t OP_REMOVE = 3'd3;
  localparam kind_t OP_CLEAR  = 3'd4;

  // Result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic    latch_in;     // capture the input beat
    logic    init_res;     // clear result word, set status
    status_t res_status;
    logic    do_append;    // write at tail, count up
    logic    clr_count;    // empty the list
    logic    rd_pos;       // read entry at position
    logic    cap_word;     // result word <= read data
    logic    wr_set;       // write new word at position
    logic    shift_start;  // idx <= position, read position+1
    logic    shift_step;   // move one entry down, read idx+2
    logic    dec_count;    // count down after remove
    logic    load_out;     // push result into output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    kind_t kind;
    logic  is_full;
    logic  pos_ok;
    logic  more_first;
    logic  more_next;
    logic  out_free;
  } sts_t;

endpackage

@@ rtl/core/cal_if.sv @@
// ----------------------------------------------------------------------------
// cal_if
// Valid/ready channels for list requests and list results.
// ----------------------------------------------------------------------------
interface cal_in_if;
  import cal_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  pos_t  position;
  data_t data_word;

  modport source (output valid, kind, position, data_word, input ready);
  modport sink   (input valid, kind, position, data_word, output ready);
endinterface

interface cal_out_if;
  import cal_pkg::*;

  logic    valid;
  logic    ready;
  data_t   read_word;
  status_t status;
  cnt_t    entry_count;

  modport source (output valid, read_word, status, entry_count, input ready);
  modport sink   (input valid, read_word, status, entry_count, output ready);
endinterface

@@ rtl/core/compacting_array_list.sv @@
// ----------------------------------------------------------------------------
// compacting_array_list
// Fixed-capacity ordered word list: append, get, set, remove with
// compaction, and clear, one request at a time.
//
//   channel  dir  beat contents
//   in_bus   in   kind, position, data_word
//   out_bus  out  read_word, status, entry_count
//
// Steps per request with the output free: append, clear, unused codes and
// out-of-range requests pass idle, execute and done; get and set add a read;
// remove adds the read and one shift step per entry moved, one per cycle.
// The result register loads in the cycle before the next accept can happen.
// A waiting result stalls the controller only if the next request is done.
// Reset (rst_n low, synchronous) empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
module compacting_array_list #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input logic         clk,
  input logic         rst_n,
  cal_in_if.sink      in_bus,
  cal_out_if.source   out_bus
);
  import cal_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_bus.ready = in_ready;

  // Sequencer
  cal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and result path
  cal_dp #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_bus.kind),
    .in_position     (in_bus.position),
    .in_data_word    (in_bus.data_word),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_read_word   (out_bus.read_word),
    .out_status      (out_bus.status),
    .out_entry_count (out_bus.entry_count)
  );

endmodule

@@ rtl/core/cal_dp.sv @@
// ----------------------------------------------------------------------------
// cal_dp
// List datapath: entry memory, count, shift index, result and output
// registers. Acts only on controller commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cal_dp #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cal_pkg::cmd_t   cmd,
  output cal_pkg::sts_t   sts,
  input  cal_pkg::kind_t  in_kind,
  input  cal_pkg::pos_t   in_position,
  input  cal_pkg::data_t  in_data_word,
  output logic            out_valid,
  input  logic            out_ready,
  output cal_pkg::data_t  out_read_word,
  output cal_pkg::status_t out_status,
  output cal_pkg::cnt_t   out_entry_count
);
  import cal_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 2;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [IW-1:0]         idx_t;
  typedef logic [CW-1:0]         count_t;

  // Entry store
  word_t mem [CAPACITY];

  kind_t   kind_r;
  pos_t    pos_r;
  word_t   word_r;
  idx_t    idx_r;
  count_t  count_r;
  word_t   rdata_r;
  word_t   res_word_r;
  status_t res_st_r;
  logic    out_valid_r;
  data_t   out_word_r;
  status_t out_st_r;
  cnt_t    out_cnt_r;

  logic    mem_we;
  idx_t    mem_waddr;
  word_t   mem_wdata;
  logic    mem_re;
  idx_t    mem_raddr;
  idx_t    pos_idx;

  assign pos_idx = IW'(pos_r);

  // Memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_idx;
    mem_wdata = word_r;
    if (cmd.do_append) begin
      mem_we    = 1'b1;
      mem_waddr = IW'(count_r);
    end else if (cmd.wr_set) begin
      mem_we    = 1'b1;
    end else if (cmd.shift_step) begin
      mem_we    = 1'b1;
      mem_waddr = idx_r;
      mem_wdata = rdata_r;
    end
  end

  always_comb begin
    mem_re    = cmd.rd_pos | cmd.shift_start | cmd.shift_step;
    mem_raddr = pos_idx;
    if (cmd.shift_start) begin
      mem_raddr = pos_idx + IW'(1);
    end else if (cmd.shift_step) begin
      mem_raddr = idx_r + IW'(2);
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      pos_r  <= in_position;
      word_r <= WORD_WIDTH'(in_data_word);
    end
    if (cmd.init_res) begin
      res_word_r <= '0;
      res_st_r   <= cmd.res_status;
    end else if (cmd.cap_word) begin
      res_word_r <= rdata_r;
    end
    if (cmd.shift_start) begin
      idx_r <= pos_idx;
    end else if (cmd.shift_step) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.load_out) begin
      out_word_r <= DATA_W'(res_word_r);
      out_st_r   <= res_st_r;
      out_cnt_r  <= CNT_W'(count_r);
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr_count) begin
      count_r <= '0;
    end else if (cmd.do_append) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.dec_count) begin
      count_r <= count_r - CW'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Status to controller
  always_comb begin
    sts.kind       = kind_r;
    sts.is_full    = XW'(count_r) >= XW'(CAPACITY);
    sts.pos_ok     = XW'(pos_r) < XW'(count_r);
    sts.more_first = (XW'(pos_r) + XW'(1)) < XW'(count_r);
    sts.more_next  = (XW'(idx_r) + XW'(2)) < XW'(count_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_read_word   = out_word_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;

  `CAL_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, XW'(count_r) <= XW'(CAPACITY), "count over capacity")
  `CAL_ASSERT_IMP(a_append_room, clk, rst_n, cmd.do_append, !sts.is_full, "append into full list")
  `CAL_ASSERT_IMP(a_shift_inside, clk, rst_n, cmd.shift_step, (XW'(idx_r) + XW'(1)) < XW'(count_r), "shift past tail")

endmodule

@@ rtl/core/cal_ctrl.sv @@
// ----------------------------------------------------------------------------
// cal_ctrl
// List controller: sequences one request at a time through the datapath,
// including the entry-by-entry compaction of a remove.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cal_pkg::sts_t sts,
  output cal_pkg::cmd_t cmd
);
  import cal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.init_res   = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_DONE;
        case (sts.kind)
          OP_APPEND: begin
            if (sts.is_full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.do_append = 1'b1;
            end
          end
          OP_GET, OP_SET, OP_REMOVE: begin
            if (!sts.pos_ok) begin
              cmd.res_status = ST_RANGE;
            end else begin
              cmd.rd_pos = 1'b1;
              state_nxt  = S_READ;
            end
          end
          OP_CLEAR: begin
            cmd.clr_count = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        cmd.cap_word = 1'b1;
        state_nxt    = S_DONE;
        if (sts.kind == OP_SET) begin
          cmd.wr_set = 1'b1;
        end else if (sts.kind == OP_REMOVE) begin
          if (sts.more_first) begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end else begin
            cmd.dec_count = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        // one entry moves down per cycle
        cmd.shift_step = 1'b1;
        if (!sts.more_next) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `CAL_ASSERT_IMP(a_shift_remove, clk, rst_n, state_r == S_SHIFT, sts.kind == OP_REMOVE, "shift outside remove")
  `CAL_ASSERT_NXT(a_load_idle, clk, rst_n, cmd.load_out, state_r == S_IDLE, "no return to idle after result")
  `CAL_ASSERT_NXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC, "beat not executed")

endmodule

@@ test/compacting_array_list_test.sv @@
// ----------------------------------------------------------------------------
// compacting_array_list_test
// Self-checking bench for the compacting array list. A shadow copy of the
// list predicts read_word, status and entry_count for every request beat, and
// result beats are compared in order. A short directed run covers the empty
// list, the word extremes, range errors, compaction and the unused codes.
// Random phases then fill, mix and drain the list, so both the full and the
// empty condition are reached. Both channels idle at random, with one calm
// stretch where neither side idles.
// ----------------------------------------------------------------------------
module compacting_array_list_test;
  import cal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_BEATS = 550;
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES  = 100;   // longer than a full-length compaction
  localparam int IDLE_PCT     = 27;

  // Codes the block takes as no-ops
  localparam kind_t OP_SPARE_FIRST = 3'd5;
  localparam kind_t OP_SPARE_MID   = 3'd6;
  localparam kind_t OP_SPARE_LAST  = 3'd7;

  // Random phase flavors
  localparam int PH_FILL  = 0;
  localparam int PH_MIXED = 1;
  localparam int PH_DRAIN = 2;

  typedef struct {
    data_t   read_word;
    status_t status;
    cnt_t    entry_count;
  } list_reply_t;

  // Shadow list: predicts each reply and checks result beats in order
  class list_shadow;
    data_t       words [LIST_DEPTH];
    int          fill;
    list_reply_t replies_due [$];
    int          errors;

    function void note_request(kind_t op, pos_t at, data_t word);
      list_reply_t r;
      r.read_word = '0;
      r.status    = ST_OK;
      case (op)
        OP_APPEND: begin
          if (fill >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            words[fill] = word;
            fill++;
          end
        end
        OP_GET, OP_SET, OP_REMOVE: begin
          if (at >= fill) begin
            r.status = ST_RANGE;
          end else begin
            r.read_word = words[at];
            if (op == OP_SET) begin
              words[at] = word;
            end else if (op == OP_REMOVE) begin
              // close the gap left by the removed entry
              for (int i = at; i + 1 < fill; i++) words[i] = words[i + 1];
              fill--;
            end
          end
        end
        OP_CLEAR: fill = 0;
        default: ;
      endcase
      r.entry_count = cnt_t'(fill);
      replies_due.push_back(r);
    endfunction

    function void check_result(data_t rw, status_t st, cnt_t cnt);
      list_reply_t want;
      if (replies_due.size() == 0) begin
        $error("unexpected result beat: read_word %h status %0d entry_count %0d",
               rw, st, cnt);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (rw !== want.read_word) begin
        $error("read_word: expected %h, got %h", want.read_word, rw);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (cnt !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   quiet_cycles = 0;

  list_shadow shadow;

  cal_in_if  in_bus ();
  cal_out_if out_bus ();

  compacting_array_list #(
    .CAPACITY   (LIST_DEPTH),
    .WORD_WIDTH (DATA_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random backpressure, none during the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      shadow.check_result(out_bus.read_word, out_bus.status, out_bus.entry_count);
    end
  end

  // Watchdog: gives up when no beat moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one request beat, with random idle cycles ahead of it
  task automatic send_request(kind_t op, pos_t at, data_t word);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= op;
    in_bus.position  <= at;
    in_bus.data_word <= word;
    do @(posedge clk); while (!in_bus.ready);
    shadow.note_request(op, at, word);
  endtask

  // One random request shaped by the current phase
  task automatic send_random(int phase);
    int    fill;
    int    roll;
    int    to_append;
    int    to_get;
    int    to_set;
    kind_t op;
    pos_t  at;
    data_t word;
    fill = shadow.fill;
    case (phase)
      PH_FILL:  begin to_append = 85; to_get = 93; to_set = 100; end
      PH_MIXED: begin to_append = 38; to_get = 58; to_set = 78;  end
      default:  begin to_append = 14; to_get = 34; to_set = 50;  end
    endcase
    roll = $urandom_range(99);
    if (roll < 2) begin
      op = kind_t'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end else if (roll < 4 && phase != PH_FILL) begin
      op = OP_CLEAR;
    end else begin
      roll = $urandom_range(99);
      if (roll < to_append)   op = OP_APPEND;
      else if (roll < to_get) op = OP_GET;
      else if (roll < to_set) op = OP_SET;
      else                    op = OP_REMOVE;
    end
    // mostly live positions, the tail entry often, sometimes anything
    roll = $urandom_range(99);
    if (fill > 0 && roll < 12)      at = pos_t'(fill - 1);
    else if (fill > 0 && roll < 85) at = pos_t'($urandom_range(fill - 1));
    else                            at = pos_t'($urandom_range(LIST_DEPTH - 1));
    roll = $urandom_range(99);
    if (roll < 8)       word = '0;
    else if (roll < 16) word = '1;
    else                word = data_t'($urandom());
    send_request(op, at, word);
  endtask

  // Stimulus and end of run
  initial begin
    int phase;
    int phase_left;
    shadow           = new();
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.kind      <= OP_GET;
    in_bus.position  <= '0;
    in_bus.data_word <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every indexed request is out of range
    send_request(OP_GET,    6'd0,  32'h1111_1111);
    send_request(OP_REMOVE, 6'd0,  32'h2222_2222);
    send_request(OP_SET,    6'd0,  32'hFFFF_FFFF);
    // word extremes
    send_request(OP_APPEND, 6'd63, 32'h0000_0000);
    send_request(OP_APPEND, 6'd0,  32'hFFFF_FFFF);
    send_request(OP_APPEND, 6'd0,  32'hA5A5_A5A5);
    send_request(OP_GET,    6'd0,  32'h0);
    send_request(OP_GET,    6'd2,  32'h0);
    // index equal to count, and the top index
    send_request(OP_GET,    6'd3,  32'h0);
    send_request(OP_GET,    6'd63, 32'hFFFF_FFFF);
    send_request(OP_SET,    6'd1,  32'h1234_5678);
    send_request(OP_APPEND, 6'd0,  32'h5A5A_5A5A);
    // remove at the head compacts the whole list
    send_request(OP_REMOVE, 6'd0,  32'h0);
    send_request(OP_GET,    6'd0,  32'h0);
    // remove at the tail moves nothing
    send_request(OP_REMOVE, 6'd2,  32'h0);
    // unused codes leave the list alone
    send_request(OP_SPARE_FIRST, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_SPARE_MID,   6'd0,  32'hFFFF_FFFF);
    send_request(OP_SPARE_LAST,  6'd1,  32'h0);
    send_request(OP_REMOVE, 6'd0,  32'h0);
    send_request(OP_CLEAR,  6'd63, 32'hFFFF_FFFF);
    send_request(OP_GET,    6'd0,  32'h0);
    send_request(OP_APPEND, 6'd0,  32'hC001_D00D);
    send_request(OP_REMOVE, 6'd1,  32'h0);

    // random phases: start by filling so the full list is reached
    phase      = PH_FILL;
    phase_left = 100;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= 250 && n < 350);
      if (phase_left == 0) begin
        phase      = (phase == PH_DRAIN) ? PH_FILL : phase + 1;
        phase_left = $urandom_range(90, 40);
      end
      phase_left--;
      send_random(phase);
    end
    calm = 1'b0;
    in_bus.valid <= 1'b0;

    // drain, then watch for stray results
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cal_pkg.sv
rtl/core/cal_if.sv
rtl/core/cal_dp.sv
rtl/core/cal_ctrl.sv
rtl/core/compacting_array_list.sv
test/compacting_array_list_test.sv
